### rtl/scac_pkg.sv
package scac_pkg;

    // Default fixed-point format and slope width
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SLOPE_WIDTH_DEF = 24;

    // Field widths
    localparam int THR_W      = 17;  // unsigned threshold / level registers
    localparam int GAIN_W     = 18;  // signed makeup gain
    localparam int SAMPLE_W   = 18;  // signed input sample
    localparam int RESULT_W   = 19;  // signed output sample
    localparam int MAG_W      = 18;  // sample magnitude, up to 131072
    localparam int OFF_W      = 20;  // signed offset added after the ramp product
    localparam int NUM_W      = 20;  // signed slope numerator
    localparam int NUM_MAG_W  = 19;  // magnitude of the slope numerator
    localparam int DEN_W      = 18;  // signed slope denominator
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_END     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THR       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAKEUP_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd5;

    typedef struct packed {
        logic [THR_W-1:0]         gate_end;
        logic [THR_W-1:0]         up_thr;
        logic [THR_W-1:0]         down_thr;
        logic [THR_W-1:0]         limit_start;
        logic signed [GAIN_W-1:0] makeup_gain;
        logic [THR_W-1:0]         max_level;
    } curve_cfg_t;

    localparam curve_cfg_t CURVE_RESET = '{
        gate_end:    17'd0,
        up_thr:      17'd16384,
        down_thr:    17'd49152,
        limit_start: 17'd65536,
        makeup_gain: 18'sd0,
        max_level:   17'd65536
    };

    // Which ramp slope multiplies the difference
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_GATE,
        SEL_COMP
    } slope_sel_t;

    // One classified sample travelling from front to back
    typedef struct packed {
        logic                    neg;
        slope_sel_t              sel;
        logic [MAG_W-1:0]        diff;
        logic signed [OFF_W-1:0] offset;
    } curve_op_t;

endpackage

### rtl/scac_cfg.sv
module scac_cfg
    import scac_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SLOPE_WIDTH = SLOPE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output curve_cfg_t                    curve,
    output logic signed [SLOPE_WIDTH-1:0] gate_slope,
    output logic signed [SLOPE_WIDTH-1:0] comp_slope,
    output logic                          busy
);

    localparam int DIV_W = NUM_MAG_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam int CMP_W = ((DIV_W > SLOPE_WIDTH) ? DIV_W : SLOPE_WIDTH) + 1;

    localparam logic [CMP_W-1:0] MAX_MAG = (CMP_W'(1) << (SLOPE_WIDTH - 1)) - CMP_W'(1);
    localparam logic [CMP_W-1:0] MIN_MAG = CMP_W'(1) << (SLOPE_WIDTH - 1);
    localparam logic [SLOPE_WIDTH-1:0] SLOPE_ONE = (FRAC_BITS < SLOPE_WIDTH - 1) ?
        (SLOPE_WIDTH'(1) << FRAC_BITS) : SLOPE_WIDTH'(MAX_MAG);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                        state_reg, state_next;
    logic                          comp_phase_reg, comp_phase_next;
    curve_cfg_t                    curve_reg, curve_next;
    logic signed [SLOPE_WIDTH-1:0] gate_slope_reg, gate_slope_next;
    logic signed [SLOPE_WIDTH-1:0] comp_slope_reg, comp_slope_next;

    // divider datapath
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [THR_W-1:0] rem_reg, rem_next;
    logic [THR_W-1:0] den_reg, den_next;
    logic             neg_reg, neg_next;
    logic             zero_reg, zero_next;

    logic signed [NUM_W-1:0] num_gate, num_comp, num_sel, num_abs;
    logic signed [DEN_W-1:0] den_gate, den_comp, den_sel;
    logic [THR_W:0]          rem_sh;
    logic                    rem_ge;
    logic [CMP_W-1:0]        quo_ext, lim, sat_mag, slope_wide;
    logic [SLOPE_WIDTH-1:0]  slope_val;
    logic                    wr_en;

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = !busy;
    assign curve      = curve_reg;
    assign gate_slope = gate_slope_reg;
    assign comp_slope = comp_slope_reg;
    assign wr_en      = cfg_valid && cfg_ready;

    // slope terms
    assign num_gate = NUM_W'(signed'({1'b0, curve_reg.up_thr}))
                    + NUM_W'(curve_reg.makeup_gain);
    assign num_comp = NUM_W'(signed'({1'b0, curve_reg.max_level}))
                    - NUM_W'(signed'({1'b0, curve_reg.down_thr}))
                    - NUM_W'(curve_reg.makeup_gain);
    assign den_gate = signed'({1'b0, curve_reg.up_thr})
                    - signed'({1'b0, curve_reg.gate_end});
    assign den_comp = signed'({1'b0, curve_reg.limit_start})
                    - signed'({1'b0, curve_reg.down_thr});
    assign num_sel  = comp_phase_reg ? num_comp : num_gate;
    assign den_sel  = comp_phase_reg ? den_comp : den_gate;
    assign num_abs  = num_sel[NUM_W-1] ? -num_sel : num_sel;

    // one restoring step
    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    // saturate and apply sign
    assign quo_ext    = CMP_W'(quo_reg);
    assign lim        = neg_reg ? MIN_MAG : MAX_MAG;
    assign sat_mag    = (quo_ext > lim) ? lim : quo_ext;
    assign slope_wide = neg_reg ? -sat_mag : sat_mag;
    assign slope_val  = zero_reg ? '0 : slope_wide[SLOPE_WIDTH-1:0];

    always_comb
    begin
        state_next      = state_reg;
        comp_phase_next = comp_phase_reg;
        curve_next      = curve_reg;
        gate_slope_next = gate_slope_reg;
        comp_slope_next = comp_slope_reg;
        cnt_next        = cnt_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        den_next        = den_reg;
        neg_next        = neg_reg;
        zero_next       = zero_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (wr_en)
                begin
                    comp_phase_next = 1'b0;
                    state_next      = ST_LOAD;
                    case (cfg_index)
                        REG_GATE_END:    curve_next.gate_end    = cfg_data[THR_W-1:0];
                        REG_UP_THR:      curve_next.up_thr      = cfg_data[THR_W-1:0];
                        REG_DOWN_THR:    curve_next.down_thr    = cfg_data[THR_W-1:0];
                        REG_LIMIT_START: curve_next.limit_start = cfg_data[THR_W-1:0];
                        REG_MAKEUP_GAIN: curve_next.makeup_gain = signed'(cfg_data);
                        REG_MAX_LEVEL:   curve_next.max_level   = cfg_data[THR_W-1:0];
                        default:         state_next             = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                quo_next   = {num_abs[NUM_MAG_W-1:0], {FRAC_BITS{1'b0}}};
                rem_next   = '0;
                den_next   = den_sel[THR_W-1:0];
                neg_next   = num_sel[NUM_W-1];
                zero_next  = den_sel[DEN_W-1] || (den_sel == '0);
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[DIV_W-2:0], rem_ge};
                rem_next = rem_ge ? THR_W'(rem_sh - {1'b0, den_reg}) : rem_sh[THR_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (comp_phase_reg)
                begin
                    comp_slope_next = slope_val;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    gate_slope_next = slope_val;
                    comp_phase_next = 1'b1;
                    state_next      = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            comp_phase_reg <= 1'b0;
            curve_reg      <= CURVE_RESET;
            gate_slope_reg <= signed'(SLOPE_ONE);
            comp_slope_reg <= signed'(SLOPE_ONE);
        end
        else
        begin
            state_reg      <= state_next;
            comp_phase_reg <= comp_phase_next;
            curve_reg      <= curve_next;
            gate_slope_reg <= gate_slope_next;
            comp_slope_reg <= comp_slope_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // a write to a known register always starts a slope update
    a_write_starts_update: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (cfg_index <= REG_MAX_LEVEL)) |=> busy)
        else $error("register write did not start slope update");

    // slopes only change in the finishing step of the divider
    a_slopes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FIN) |=> ($stable(gate_slope_reg) && $stable(comp_slope_reg)))
        else $error("slope changed outside the finishing step");

endmodule

### rtl/scac_front.sv
module scac_front
    import scac_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  curve_cfg_t                 curve,
    input  logic                       cfg_busy,
    input  logic                       cfg_valid,
    input  logic                       queue_full,
    output logic                       push,
    output curve_op_t                  push_op
);

    localparam int MCMP_W = (MAG_W > FRAC_BITS + 2) ? MAG_W : FRAC_BITS + 2;
    localparam logic [MCMP_W-1:0] ONE_Q = MCMP_W'(1) << FRAC_BITS;

    logic             f_valid_reg, f_valid_next;
    curve_op_t        f_op_reg;
    curve_op_t        op;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             accept;

    assign neg = sample_in[SAMPLE_W-1];
    assign mag = neg ? MAG_W'(-sample_in) : MAG_W'(sample_in);

    // classify by magnitude, first matching region wins
    always_comb
    begin
        op.neg    = neg;
        op.sel    = SEL_NONE;
        op.diff   = mag - MAG_W'(curve.gate_end);
        op.offset = '0;
        if (MCMP_W'(mag) > ONE_Q)
        begin
            op.neg    = 1'b0;
            op.offset = OFF_W'(sample_in);
        end
        else if (mag <= MAG_W'(curve.gate_end))
        begin
            op.offset = '0;
        end
        else if (mag <= MAG_W'(curve.up_thr))
        begin
            op.sel = SEL_GATE;
        end
        else if (mag <= MAG_W'(curve.down_thr))
        begin
            op.offset = OFF_W'(signed'({1'b0, mag})) + OFF_W'(curve.makeup_gain);
        end
        else if (mag <= MAG_W'(curve.limit_start))
        begin
            op.sel    = SEL_COMP;
            op.diff   = mag - MAG_W'(curve.down_thr);
            op.offset = OFF_W'(signed'({1'b0, curve.down_thr}))
                      + OFF_W'(curve.makeup_gain);
        end
        else
        begin
            op.offset = OFF_W'(signed'({1'b0, curve.max_level}));
        end
    end

    assign sample_stall = cfg_busy || cfg_valid || (f_valid_reg && queue_full);
    assign accept       = sample_valid && !sample_stall;
    assign push         = f_valid_reg && !queue_full;
    assign push_op      = f_op_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_op_reg <= op;
        end
    end

endmodule

### rtl/scac_fifo.sv
module scac_fifo
    import scac_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  curve_op_t push_op,
    output logic      full,
    input  logic      pop,
    output curve_op_t pop_op,
    output logic      empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    curve_op_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

endmodule

### rtl/scac_back.sv
module scac_back
    import scac_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SLOPE_WIDTH = SLOPE_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  curve_op_t                     pop_op,
    output logic                          pop,
    input  logic signed [SLOPE_WIDTH-1:0] gate_slope,
    input  logic signed [SLOPE_WIDTH-1:0] comp_slope,
    output logic                          shaped_valid,
    input  logic                          shaped_stall,
    output logic signed [RESULT_W-1:0]    sample_out
);

    localparam int PROD_W = MAG_W + 1 + SLOPE_WIDTH;
    localparam int Y_W    = PROD_W + 2;
    localparam logic signed [Y_W-1:0] OUT_MAX = (Y_W'(1) << (RESULT_W - 1)) - Y_W'(1);
    localparam logic signed [Y_W-1:0] OUT_MIN = -(Y_W'(1) << (RESULT_W - 1));

    logic                          m_valid_reg, m_valid_next;
    logic signed [PROD_W-1:0]      m_prod_reg;
    logic signed [OFF_W-1:0]       m_off_reg;
    logic                          m_neg_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [RESULT_W-1:0]    out_data_reg;

    logic signed [SLOPE_WIDTH-1:0] slope;
    logic signed [PROD_W-1:0]      prod;
    logic signed [Y_W-1:0]         y_pos, y;
    logic signed [RESULT_W-1:0]    y_sat;
    logic                          o_free, o_load, m_free;

    assign o_free = !out_valid_reg || !shaped_stall;
    assign o_load = m_valid_reg && o_free;
    assign m_free = !m_valid_reg || o_free;
    assign pop    = !queue_empty && m_free;

    always_comb
    begin
        case (pop_op.sel)
            SEL_GATE: slope = gate_slope;
            SEL_COMP: slope = comp_slope;
            default:  slope = '0;
        endcase
    end

    assign prod = PROD_W'(signed'({1'b0, pop_op.diff})) * PROD_W'(slope);

    // floor the product, add offset, mirror and clamp
    assign y_pos = (Y_W'(m_prod_reg) >>> FRAC_BITS) + Y_W'(m_off_reg);
    assign y     = m_neg_reg ? -y_pos : y_pos;

    always_comb
    begin
        if (y > OUT_MAX)
        begin
            y_sat = OUT_MAX[RESULT_W-1:0];
        end
        else if (y < OUT_MIN)
        begin
            y_sat = OUT_MIN[RESULT_W-1:0];
        end
        else
        begin
            y_sat = y[RESULT_W-1:0];
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (pop)
        begin
            m_valid_next = 1'b1;
        end
        else if (o_load)
        begin
            m_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (o_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!shaped_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            m_prod_reg <= prod;
            m_off_reg  <= pop_op.offset;
            m_neg_reg  <= pop_op.neg;
        end
        if (o_load)
        begin
            out_data_reg <= y_sat;
        end
    end

    assign shaped_valid = out_valid_reg;
    assign sample_out   = out_data_reg;

endmodule

### rtl/static_curve_audio_compressor.sv
// Static piecewise-linear curve for audio samples: gate, gate ramp, offset
// region, compression ramp and limiter, mirrored for negative samples.
//
// Sample channel: sample_valid / sample_stall carry one signed Q.16 sample
// per beat on sample_in. Shaped channel: shaped_valid / shaped_stall carry
// one shaped sample per beat on sample_out. A beat moves when valid is high
// and stall is low.
// Config channel: cfg_valid / cfg_ready, cfg_index picks the register,
// cfg_data holds the value. Write only while no sample is in flight. Each
// write to a known register recomputes both ramp slopes with a shared
// bit-serial divider, one quotient bit per cycle. sample_stall and
// cfg_ready hold off new beats during that update. Throughput: one sample
// per cycle unless the receiver, a write or a slope update holds it off.
// A sample goes through the front register, queue, multiply and output.
// When the receiver stalls, the output register holds its sample, the back
// stages and the queue fill, and sample_stall rises only once the queue is
// full. Reset clears all pipeline valids and the queue, loads the default
// curve and sets both slopes to 1.0.
module static_curve_audio_compressor
    import scac_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int SLOPE_WIDTH = SLOPE_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       shaped_valid,
    input  logic                       shaped_stall,
    output logic signed [RESULT_W-1:0] sample_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    curve_cfg_t                    curve;
    logic signed [SLOPE_WIDTH-1:0] gate_slope;
    logic signed [SLOPE_WIDTH-1:0] comp_slope;
    logic                          cfg_busy;
    logic                          push, pop, queue_full, queue_empty;
    curve_op_t                     push_op, pop_op;

    // Registers and slope divider
    scac_cfg #(
        .FRAC_BITS   (FRAC_BITS),
        .SLOPE_WIDTH (SLOPE_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .curve      (curve),
        .gate_slope (gate_slope),
        .comp_slope (comp_slope),
        .busy       (cfg_busy)
    );

    // Front: take the sample, find its region, pick the ramp operands
    scac_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .curve        (curve),
        .cfg_busy     (cfg_busy),
        .cfg_valid    (cfg_valid),
        .queue_full   (queue_full),
        .push         (push),
        .push_op      (push_op)
    );

    // Queue: decouple front from output backpressure
    scac_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .full    (queue_full),
        .pop     (pop),
        .pop_op  (pop_op),
        .empty   (queue_empty)
    );

    // Back: multiply by the slope, add offset, mirror, clamp
    scac_back #(
        .FRAC_BITS   (FRAC_BITS),
        .SLOPE_WIDTH (SLOPE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_empty  (queue_empty),
        .pop_op       (pop_op),
        .pop          (pop),
        .gate_slope   (gate_slope),
        .comp_slope   (comp_slope),
        .shaped_valid (shaped_valid),
        .shaped_stall (shaped_stall),
        .sample_out   (sample_out)
    );

    // no sample enters while the slopes are being recomputed
    a_no_sample_during_update: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |-> !cfg_busy)
        else $error("sample taken during slope update");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import scac_pkg::*;
;

    // Spare register indexes past the end of the register map; writes to
    // them must leave the curve untouched.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // Fixed-point constants of the curve arithmetic
    localparam int     SLOPE_W   = SLOPE_WIDTH_DEF;
    localparam longint UNITY     = longint'(1) << FRAC_BITS_DEF;
    localparam longint SLOPE_TOP = (longint'(1) << (SLOPE_W - 1)) - 1;
    localparam longint SLOPE_BOT = -(longint'(1) << (SLOPE_W - 1));
    localparam longint OUT_TOP   = (longint'(1) << (RESULT_W - 1)) - 1;
    localparam longint OUT_BOT   = -(longint'(1) << (RESULT_W - 1));
    localparam int     PHASES    = 8;
    localparam int     PHASE_LEN = 90;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       shaped_valid;
    logic                       shaped_stall = 1'b0;
    logic signed [RESULT_W-1:0] sample_out;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    static_curve_audio_compressor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_in    (sample_in),
        .shaped_valid (shaped_valid),
        .shaped_stall (shaped_stall),
        .sample_out   (sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the curve registers and the two derived ramp slopes
    curve_cfg_t                curve = CURVE_RESET;
    logic signed [SLOPE_W-1:0] gate_slope = SLOPE_W'(UNITY);
    logic signed [SLOPE_W-1:0] comp_slope = SLOPE_W'(UNITY);

    // Shaped samples still owed by the block, oldest first
    logic signed [RESULT_W-1:0] shaped_due[$];
    int  fault_count = 0;
    bit  calm = 1'b0;   // no idling on either side while set

    // One row of the directed script: a register write or a sample beat,
    // the latter with a typed-in result where one is given.
    typedef struct {
        bit                         is_cfg;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic signed [SAMPLE_W-1:0] smp;
        bit                         typed;
        logic signed [RESULT_W-1:0] want;
    } script_row_t;

    script_row_t script[$];

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Slope of a ramp: truncating division, empty ramps give zero, and the
    // quotient saturates at the slope width.
    function automatic logic signed [SLOPE_W-1:0] ramp_slope(input longint num,
                                                             input longint den);
        longint q;
        if (den <= 0)
            return '0;
        q = (num * UNITY) / den;
        if (q > SLOPE_TOP)
            q = SLOPE_TOP;
        if (q < SLOPE_BOT)
            q = SLOPE_BOT;
        return q[SLOPE_W-1:0];
    endfunction

    function automatic void refresh_slopes();
        longint gain;
        gain = longint'($signed(curve.makeup_gain));
        gate_slope = ramp_slope(longint'(curve.up_thr) + gain,
                                longint'(curve.up_thr) - longint'(curve.gate_end));
        comp_slope = ramp_slope(longint'(curve.max_level) - longint'(curve.down_thr) - gain,
                                longint'(curve.limit_start) - longint'(curve.down_thr));
    endfunction

    // Mirror one register write; spare indexes are dropped, bits above
    // the register width are dropped.
    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GATE_END:    curve.gate_end    = data[THR_W-1:0];
            REG_UP_THR:      curve.up_thr      = data[THR_W-1:0];
            REG_DOWN_THR:    curve.down_thr    = data[THR_W-1:0];
            REG_LIMIT_START: curve.limit_start = data[THR_W-1:0];
            REG_MAKEUP_GAIN: curve.makeup_gain = data[GAIN_W-1:0];
            REG_MAX_LEVEL:   curve.max_level   = data[THR_W-1:0];
            default:         return;
        endcase
        refresh_slopes();
    endfunction

    // Shape one sample: classify the magnitude by the first matching
    // region, mirror for negative samples, saturate to the output width.
    function automatic logic signed [RESULT_W-1:0] shape_sample(
        input logic signed [SAMPLE_W-1:0] s);
        longint x, m, y, ge, ut, dt, ls, mg, ml;
        bit     neg, thru;
        x    = longint'(s);
        neg  = (x < 0);
        m    = neg ? -x : x;
        ge   = longint'(curve.gate_end);
        ut   = longint'(curve.up_thr);
        dt   = longint'(curve.down_thr);
        ls   = longint'(curve.limit_start);
        mg   = longint'($signed(curve.makeup_gain));
        ml   = longint'(curve.max_level);
        thru = 1'b0;
        y    = 0;
        if (m > UNITY)
            thru = 1'b1;
        else if (m <= ge)
            y = 0;
        else if (m <= ut)
            y = ((m - ge) * longint'(gate_slope)) >>> FRAC_BITS_DEF;
        else if (m <= dt)
            y = m + mg;
        else if (m <= ls)
            y = (((m - dt) * longint'(comp_slope)) >>> FRAC_BITS_DEF) + dt + mg;
        else if (m > ls)
            y = ml;
        else
            thru = 1'b1;
        if (thru)
            y = x;
        else if (neg)
            y = -y;
        if (y > OUT_TOP)
            y = OUT_TOP;
        if (y < OUT_BOT)
            y = OUT_BOT;
        return y[RESULT_W-1:0];
    endfunction

    // Idle cycles before the next sample beat: mostly none, some short,
    // a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one sample beat and hold it until taken. Valid stays high on
    // return so that back-to-back beats never drop it within a step.
    task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input int gap,
                               input bit typed, input logic signed [RESULT_W-1:0] want);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= s;
        do
            @(posedge clk);
        while (sample_stall);
        shaped_due.push_back(typed ? want : shape_sample(s));
    endtask

    // Drop sample valid and wait until every owed result has come back.
    task automatic drain_idle();
        sample_valid <= 1'b0;
        while (shaped_due.size() != 0)
            @(posedge clk);
    endtask

    // One register write beat; the block holds off ready while it
    // recomputes the slopes, so just wait for the handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        store_reg(idx, data);
    endtask

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        script_row_t row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        return row;
    endfunction

    function automatic script_row_t smp_row(input logic signed [SAMPLE_W-1:0] s,
                                            input bit typed,
                                            input logic signed [RESULT_W-1:0] want);
        script_row_t row;
        row       = '{default: '0};
        row.smp   = s;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    // Receiver side: alternate runs of stall and go. Stall runs are now and
    // then long enough to back up the queue.
    initial
    begin
        int run;
        bit hold;
        run  = 0;
        hold = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                hold = ~hold;
                if (hold)
                    run = ($urandom_range(99) < 85) ? $urandom_range(3, 1)
                                                    : $urandom_range(60, 10);
                else
                    run = $urandom_range(25, 1);
            end
            shaped_stall <= hold && !calm;
            run = run - 1;
        end
    end

    // Check every result beat against the oldest owed sample.
    always @(posedge clk)
    begin
        logic signed [RESULT_W-1:0] want;
        if (rst_n && shaped_valid && !shaped_stall)
        begin
            if (shaped_due.size() == 0)
            begin
                if (fault_count < 10)
                    $display("%0t: result %0d with nothing owed", $realtime, sample_out);
                fault_count++;
            end
            else
            begin
                want = shaped_due.pop_front();
                if (sample_out !== want)
                begin
                    if (fault_count < 10)
                        $display("%0t: sample_out expected %0d, got %0d",
                                 $realtime, want, sample_out);
                    fault_count++;
                end
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5000000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        int                         ph, k, r;
        longint                     a, b, c, d, gain, lvl, mag, base;
        logic signed [SAMPLE_W-1:0] s;

        // Hold reset at the start, then release it once.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default curve is the identity inside full scale, and full-scale
        // overruns pass through, so these rows read off directly.
        script.push_back(smp_row(18'sd0, 1'b1, 19'sd0));
        script.push_back(smp_row(18'sd1, 1'b1, 19'sd1));
        script.push_back(smp_row(-18'sd1, 1'b1, -19'sd1));
        script.push_back(smp_row(18'sd16384, 1'b1, 19'sd16384));
        script.push_back(smp_row(-18'sd16384, 1'b1, -19'sd16384));
        script.push_back(smp_row(18'sd16385, 1'b1, 19'sd16385));
        script.push_back(smp_row(18'sd49152, 1'b1, 19'sd49152));
        script.push_back(smp_row(18'sd49153, 1'b1, 19'sd49153));
        script.push_back(smp_row(18'sd65535, 1'b1, 19'sd65535));
        script.push_back(smp_row(18'sd65536, 1'b1, 19'sd65536));
        script.push_back(smp_row(-18'sd65536, 1'b1, -19'sd65536));
        script.push_back(smp_row(18'sd65537, 1'b1, 19'sd65537));
        script.push_back(smp_row(-18'sd65537, 1'b1, -19'sd65537));
        script.push_back(smp_row(18'sd131071, 1'b1, 19'sd131071));
        script.push_back(smp_row(-18'sd131071, 1'b1, -19'sd131071));
        // Gate covering full scale: everything inside goes to zero.
        script.push_back(cfg_row(REG_GATE_END, 18'd65536));
        script.push_back(smp_row(18'sd65536, 1'b1, 19'sd0));
        script.push_back(smp_row(-18'sd1, 1'b1, 19'sd0));
        script.push_back(smp_row(18'sd65537, 1'b1, 19'sd65537));
        // Negative full gain, zero ceiling, a threshold written with a
        // stray top bit, and spare indexes that must be ignored.
        script.push_back(cfg_row(REG_GATE_END, 18'd8192));
        script.push_back(cfg_row(REG_UP_THR, 18'h2_8000));
        script.push_back(cfg_row(REG_MAKEUP_GAIN, 18'h3_0000));
        script.push_back(cfg_row(REG_MAX_LEVEL, 18'd0));
        script.push_back(cfg_row(IDX_SPARE_LO, 18'h3_FFFF));
        script.push_back(cfg_row(IDX_SPARE_HI, 18'h0_0001));
        script.push_back(smp_row(18'sd20000, 1'b0, '0));
        script.push_back(smp_row(-18'sd40000, 1'b0, '0));
        script.push_back(smp_row(18'sd60000, 1'b0, '0));
        script.push_back(smp_row(18'sd65536, 1'b0, '0));
        // Positive full gain and an empty compression ramp.
        script.push_back(cfg_row(REG_MAKEUP_GAIN, 18'h1_0000));
        script.push_back(cfg_row(REG_DOWN_THR, 18'd0));
        script.push_back(cfg_row(REG_LIMIT_START, 18'd0));
        script.push_back(smp_row(18'sd32768, 1'b0, '0));
        script.push_back(smp_row(-18'sd50000, 1'b0, '0));
        script.push_back(smp_row(18'sd0, 1'b1, 19'sd0));

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain_idle();
                write_reg(script[i].idx, script[i].data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                push_sample(script[i].smp, pick_gap(), script[i].typed, script[i].want);
            end
        end

        // Random phases: rewrite the whole curve while idle, then stream.
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_idle();
            case (ph)
                0:
                begin
                    a = 0; b = 0; c = 0; d = 0; gain = 0; lvl = 0;
                end
                1:
                begin
                    a = UNITY; b = UNITY; c = UNITY; d = UNITY; gain = UNITY; lvl = UNITY;
                end
                3:
                begin
                    // thresholds in any order
                    a    = $urandom_range(65536);
                    b    = $urandom_range(65536);
                    c    = $urandom_range(65536);
                    d    = $urandom_range(65536);
                    gain = longint'($urandom_range(131072)) - UNITY;
                    lvl  = $urandom_range(65536);
                end
                default:
                begin
                    a    = $urandom_range(65536);
                    b    = a + $urandom_range(int'(UNITY - a));
                    c    = b + $urandom_range(int'(UNITY - b));
                    d    = c + $urandom_range(int'(UNITY - c));
                    gain = (ph == 2) ? -UNITY : longint'($urandom_range(131072)) - UNITY;
                    lvl  = $urandom_range(65536);
                end
            endcase
            write_reg(REG_GATE_END, {1'($urandom_range(1)), 17'(a)});
            write_reg(REG_UP_THR, {1'($urandom_range(1)), 17'(b)});
            write_reg(REG_DOWN_THR, {1'($urandom_range(1)), 17'(c)});
            write_reg(REG_LIMIT_START, {1'($urandom_range(1)), 17'(d)});
            write_reg(REG_MAKEUP_GAIN, 18'(gain));
            write_reg(REG_MAX_LEVEL, {1'($urandom_range(1)), 17'(lvl)});
            if ($urandom_range(3) == 0)
                write_reg(IDX_SPARE_HI, 18'($urandom));
            cfg_valid <= 1'b0;
            calm = (ph % 3 == 2);

            for (k = 0; k < PHASE_LEN; k++)
            begin
                r = $urandom_range(9);
                if (r < 3)
                begin
                    // land on or next to a region edge
                    case ($urandom_range(5))
                        0:       base = longint'(curve.gate_end);
                        1:       base = longint'(curve.up_thr);
                        2:       base = longint'(curve.down_thr);
                        3:       base = longint'(curve.limit_start);
                        4:       base = UNITY;
                        default: base = 0;
                    endcase
                    mag = base + $urandom_range(4) - 2;
                end
                else if (r < 7)
                    mag = $urandom_range(65536);
                else if (r < 9)
                    mag = $urandom_range(131071);
                else
                begin
                    case ($urandom_range(3))
                        0:       mag = 0;
                        1:       mag = UNITY;
                        2:       mag = UNITY + 1;
                        default: mag = 131071;
                    endcase
                end
                if (mag < 0)
                    mag = 0;
                if (mag > 131071)
                    mag = 131071;
                s = $urandom_range(1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
                push_sample(s, pick_gap(), 1'b0, '0);
            end
        end

        // Let the pipeline empty, then watch a little longer for strays.
        drain_idle();
        repeat (20) @(posedge clk);
        if (fault_count == 0 && shaped_due.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
